/* design/multiplexed_seven_segment_scanner_defines.svh */
// assertion macros shared by the scanner rtl
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// same-cycle implication
`define MSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mss_pkg.sv */
// types, constants and helpers of the seven-segment scanner
package mss_pkg;

  localparam int UNITS_DEFAULT       = 4;
  localparam int DIGIT_COUNT_DEFAULT = 4;

  localparam int DIG_W   = 4;
  localparam int VALUE_W = 24;
  localparam int DATA_W  = 16;
  localparam int POW_W   = 10;
  localparam int PROD_W  = VALUE_W + POW_W;
  localparam int FRAC_W  = 8;

  localparam logic [DIG_W-1:0] BLANK_CODE = 4'hF;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_UNIT_ENABLE    = 2'd0;
  localparam logic [1:0] REG_REFRESH_PERIOD = 2'd1;
  localparam logic [1:0] REG_COMMON_ANODE   = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  unit;
    logic [23:0] value;
    logic [1:0]  dot_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] shown_unit;
    logic [6:0] segments;
    logic       dot_level;
    logic [3:0] digit_enables;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0] unit_enable;
    logic [7:0] refresh_period;
    logic       common_anode;
  } cfg_t;

  function automatic logic [POW_W-1:0] pow10(input logic [1:0] dp);
    logic [POW_W-1:0] p;
    case (dp)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  // segment pattern a..g, bit0 is a, blank codes give zero
  function automatic logic [6:0] seg_decode(input logic [DIG_W-1:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* design/mss_regs.sv */
// apb configuration registers of the scanner
module mss_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output mss_pkg::cfg_t    cfg_o
);

  mss_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        mss_pkg::REG_UNIT_ENABLE:    cfg_d.unit_enable    = pwdata[3:0];
        mss_pkg::REG_REFRESH_PERIOD: cfg_d.refresh_period = pwdata[7:0];
        mss_pkg::REG_COMMON_ANODE:   cfg_d.common_anode   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_enable    <= 4'd0;
      cfg_q.refresh_period <= 8'd4;
      cfg_q.common_anode   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      mss_pkg::REG_UNIT_ENABLE:    prdata = {28'd0, cfg_q.unit_enable};
      mss_pkg::REG_REFRESH_PERIOD: prdata = {24'd0, cfg_q.refresh_period};
      mss_pkg::REG_COMMON_ANODE:   prdata = {31'd0, cfg_q.common_anode};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/mss_convert.sv */
// scaling and digit-serial decimal conversion of a written value
module mss_convert #(
  parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT,
  localparam int IDX_W = $clog2(DIGIT_COUNT)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mss_pkg::VALUE_W-1:0] value_i,
  input  logic [1:0]                dot_i,
  output logic                      dig_we_o,
  output logic [IDX_W-1:0]          dig_idx_o,
  output logic [mss_pkg::DIG_W-1:0] dig_data_o,
  output logic                      done_o
);

  typedef enum logic [1:0] {C_IDLE, C_SAT, C_DIG} conv_state_e;

  conv_state_e                      state_q;
  logic [mss_pkg::PROD_W-1:0]       prod_q;
  logic [mss_pkg::DATA_W-1:0]       data_q;
  logic [IDX_W-1:0]                 k_q;

  logic [mss_pkg::PROD_W-mss_pkg::FRAC_W-1:0] scaled;
  logic [mss_pkg::DATA_W-1:0]       quot;
  logic [mss_pkg::DATA_W-1:0]       quot_x10;
  logic [mss_pkg::DATA_W-1:0]       rem_full;
  logic                             k_last;

  assign scaled   = prod_q[mss_pkg::PROD_W-1:mss_pkg::FRAC_W];
  assign quot     = mss_pkg::DATA_W'((32'(data_q) * mss_pkg::DIV10_MUL) >> mss_pkg::DIV10_SHIFT);
  assign quot_x10 = mss_pkg::DATA_W'({quot, 3'b000}) + mss_pkg::DATA_W'({quot, 1'b0});
  assign rem_full = data_q - quot_x10;
  assign k_last   = (k_q == IDX_W'(DIGIT_COUNT - 1));

  assign dig_we_o   = (state_q == C_DIG);
  assign dig_idx_o  = k_q;
  assign dig_data_o = (data_q != '0) ? rem_full[mss_pkg::DIG_W-1:0] : mss_pkg::BLANK_CODE;
  assign done_o     = (state_q == C_DIG) && k_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      k_q     <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_SAT;
          end
        end
        C_SAT: begin
          k_q     <= '0;
          state_q <= C_DIG;
        end
        C_DIG: begin
          if (k_last) begin
            state_q <= C_IDLE;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == C_IDLE)) begin
      prod_q <= mss_pkg::PROD_W'(value_i) * mss_pkg::PROD_W'(mss_pkg::pow10(dot_i));
    end
    if (state_q == C_SAT) begin
      // saturate to 16 bits
      data_q <= (|scaled[$bits(scaled)-1:mss_pkg::DATA_W]) ? '1 : scaled[mss_pkg::DATA_W-1:0];
    end else if (state_q == C_DIG) begin
      data_q <= quot;
    end
  end

endmodule

/* design/mss_store.sv */
// digit memory and per-unit state memory with reset valid bits
module mss_store #(
  parameter int UNITS       = mss_pkg::UNITS_DEFAULT,
  parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT,
  localparam int UW    = (UNITS > 1) ? $clog2(UNITS) : 1,
  localparam int IDX_W = $clog2(DIGIT_COUNT)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // unit state port: {dot, scan index}
  input  logic                      ust_re_i,
  input  logic [UW-1:0]             ust_raddr_i,
  output logic [2*IDX_W-1:0]        ust_rdata_o,
  input  logic                      ust_we_i,
  input  logic [UW-1:0]             ust_waddr_i,
  input  logic [2*IDX_W-1:0]        ust_wdata_i,
  // digit port
  input  logic                      dig_re_i,
  input  logic [UW-1:0]             dig_runit_i,
  input  logic [IDX_W-1:0]          dig_ridx_i,
  output logic [mss_pkg::DIG_W-1:0] dig_rdata_o,
  input  logic                      dig_we_i,
  input  logic [UW-1:0]             dig_wunit_i,
  input  logic [IDX_W-1:0]          dig_widx_i,
  input  logic [mss_pkg::DIG_W-1:0] dig_wdata_i
);

  logic [2*IDX_W-1:0]        ust_mem_q [UNITS];
  logic [mss_pkg::DIG_W-1:0] dig_mem_q [UNITS][DIGIT_COUNT];

  logic [UNITS-1:0]          ust_vld_q;
  logic [UNITS-1:0]          row_vld_q;
  logic [2*IDX_W-1:0]        ust_rd_q;
  logic [mss_pkg::DIG_W-1:0] dig_rd_q;
  logic                      ust_rd_vld_q;
  logic                      dig_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ust_we_i) begin
      ust_mem_q[ust_waddr_i] <= ust_wdata_i;
    end
    if (ust_re_i) begin
      ust_rd_q <= ust_mem_q[ust_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_we_i) begin
      dig_mem_q[dig_wunit_i][dig_widx_i] <= dig_wdata_i;
    end
    if (dig_re_i) begin
      dig_rd_q <= dig_mem_q[dig_runit_i][dig_ridx_i];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_vld_q    <= '0;
      row_vld_q    <= '0;
      ust_rd_vld_q <= 1'b0;
      dig_rd_vld_q <= 1'b0;
    end else begin
      if (ust_we_i) begin
        ust_vld_q[ust_waddr_i] <= 1'b1;
      end
      if (dig_we_i) begin
        row_vld_q[dig_wunit_i] <= 1'b1;
      end
      if (ust_re_i) begin
        ust_rd_vld_q <= ust_vld_q[ust_raddr_i];
      end
      if (dig_re_i) begin
        dig_rd_vld_q <= row_vld_q[dig_runit_i];
      end
    end
  end

  assign ust_rdata_o = ust_rd_vld_q ? ust_rd_q : '0;
  assign dig_rdata_o = dig_rd_vld_q ? dig_rd_q : '0;

endmodule

/* design/multiplexed_seven_segment_scanner.sv */
// top level of the multiplexed seven-segment scanner
//
// Drives up to UNITS multiplexed seven-segment units of DIGIT_COUNT digits.
// A write beat (cmd = write) converts an unsigned Q16.8 value for one unit:
// it is scaled by ten to the dot position, truncated, saturated to 16 bits
// and stored as decimal digits with leading zeros blanked. It occupies the
// block for the scaling multiply, then saturation, then one step per digit
// from the digit-serial divide-by-ten unit, which writes one digit memory
// entry a cycle. A tick beat that does not end the refresh count only
// decrements it. A tick that ends it starts a scan step, which an output
// stall can lengthen: each unit needs a read of the unit state memory, then
// a read of the digit memory at its scan index, then a result beat, all
// through single read ports. Results leave through an output register, so
// the last beat of a scan may wait there while the next item is taken.
// Reset values come from per-row valid bits, so no clearing pass follows reset.

`include "multiplexed_seven_segment_scanner_defines.svh"

module multiplexed_seven_segment_scanner #(
  parameter int UNITS       = mss_pkg::UNITS_DEFAULT,
  parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mss_pkg::in_item_t  in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mss_pkg::out_item_t out_data_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int UW    = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int IDX_W = $clog2(DIGIT_COUNT);

  typedef enum logic [2:0] {ST_IDLE, ST_WRITE, ST_RD_UNIT, ST_RD_DIGIT, ST_OUT} state_e;

  state_e             state_q;
  logic [UW-1:0]      unit_q;     // unit being written
  logic [UW-1:0]      scan_u_q;   // unit being scanned
  logic [7:0]         refresh_cnt_q;
  logic               out_valid_q;
  mss_pkg::out_item_t out_q;

  mss_pkg::cfg_t      cfg;

  // handshakes
  logic in_accept;
  logic out_take;
  logic out_load;

  // write path
  logic               wr_hit;
  logic               dot_ok;
  logic [1:0]         dot_s;
  logic               conv_start;
  logic               conv_we;
  logic [IDX_W-1:0]   conv_idx;
  logic [mss_pkg::DIG_W-1:0] conv_data;
  logic               conv_done;

  // memory ports
  logic               ust_we;
  logic [UW-1:0]      ust_waddr;
  logic [2*IDX_W-1:0] ust_wdata;
  logic [2*IDX_W-1:0] ust_rdata;
  logic [mss_pkg::DIG_W-1:0] dig_rdata;

  // scan datapath
  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       cur_dot;
  logic [IDX_W-1:0]       nxt_idx;
  logic [3:0]             u_ext;
  logic                   unit_on;
  logic                   dot_on;
  logic                   scan_last;
  logic [DIGIT_COUNT-1:0] onehot;
  logic [DIGIT_COUNT-1:0] en_vec;
  mss_pkg::out_item_t     out_d;

  mss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // only idle takes an item; a pending result beat does not block it
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_take   = out_valid_q & ~out_stall_i;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // writes to units that do not exist are dropped
  assign wr_hit     = (in_data_i.cmd == mss_pkg::CMD_WRITE) && (32'(in_data_i.unit) < UNITS);
  // dot outside 1..DIGIT_COUNT-1 means no dot and no scaling
  assign dot_ok     = (in_data_i.dot_position != 2'd0) &&
                      (32'(in_data_i.dot_position) <= DIGIT_COUNT - 1);
  assign dot_s      = dot_ok ? in_data_i.dot_position : 2'd0;
  assign conv_start = in_accept && wr_hit;

  mss_convert #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_convert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (conv_start),
    .value_i    (in_data_i.value),
    .dot_i      (dot_s),
    .dig_we_o   (conv_we),
    .dig_idx_o  (conv_idx),
    .dig_data_o (conv_data),
    .done_o     (conv_done)
  );

  // unit state entry is {dot, scan index}
  assign cur_dot = ust_rdata[2*IDX_W-1:IDX_W];
  assign cur_idx = ust_rdata[IDX_W-1:0];
  assign nxt_idx = (cur_idx == IDX_W'(DIGIT_COUNT - 1)) ? '0 : cur_idx + IDX_W'(1);

  // a write clears the scan index; a shown unit advances it
  always_comb begin
    ust_we    = 1'b0;
    ust_waddr = scan_u_q;
    ust_wdata = {cur_dot, nxt_idx};
    if (conv_start) begin
      ust_we    = 1'b1;
      ust_waddr = UW'(in_data_i.unit);
      ust_wdata = {IDX_W'(dot_s), IDX_W'(0)};
    end else if (out_load && unit_on) begin
      ust_we    = 1'b1;
    end
  end

  mss_store #(
    .UNITS       (UNITS),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ust_re_i    (state_q == ST_RD_UNIT),
    .ust_raddr_i (scan_u_q),
    .ust_rdata_o (ust_rdata),
    .ust_we_i    (ust_we),
    .ust_waddr_i (ust_waddr),
    .ust_wdata_i (ust_wdata),
    .dig_re_i    (state_q == ST_RD_DIGIT),
    .dig_runit_i (scan_u_q),
    .dig_ridx_i  (cur_idx),
    .dig_rdata_o (dig_rdata),
    .dig_we_i    (conv_we),
    .dig_wunit_i (unit_q),
    .dig_widx_i  (conv_idx),
    .dig_wdata_i (conv_data)
  );

  // only the four units with an enable bit can be shown
  assign u_ext     = 4'(scan_u_q);
  assign unit_on   = (u_ext < 4'd4) && cfg.unit_enable[u_ext[1:0]];
  assign scan_last = (scan_u_q == UW'(UNITS - 1));
  assign dot_on    = unit_on && (cur_dot == cur_idx) && (cur_idx != '0);
  assign onehot    = DIGIT_COUNT'(1) << cur_idx;

  always_comb begin
    if (unit_on) begin
      en_vec = cfg.common_anode ? onehot : ~onehot;
    end else begin
      en_vec = cfg.common_anode ? '0 : '1;
    end
  end

  always_comb begin
    out_d.shown_unit    = u_ext[1:0];
    out_d.segments      = unit_on ? mss_pkg::seg_decode(dig_rdata) : 7'd0;
    out_d.dot_level     = cfg.common_anode ? ~dot_on : dot_on;
    out_d.digit_enables = 4'(en_vec);
    out_d.last          = scan_last;
  end

  // main sequencer with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      unit_q        <= '0;
      scan_u_q      <= '0;
      refresh_cnt_q <= 8'd0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data_i.cmd == mss_pkg::CMD_WRITE) begin
              if (wr_hit) begin
                unit_q  <= UW'(in_data_i.unit);
                state_q <= ST_WRITE;
              end
            end else if (refresh_cnt_q != 8'd0) begin
              refresh_cnt_q <= refresh_cnt_q - 8'd1;
            end else begin
              // count ran out: reload and walk all units
              refresh_cnt_q <= cfg.refresh_period;
              scan_u_q      <= '0;
              state_q       <= ST_RD_UNIT;
            end
          end
        end
        ST_WRITE: begin
          if (conv_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RD_UNIT:  state_q <= ST_RD_DIGIT;
        ST_RD_DIGIT: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            if (scan_last) begin
              state_q <= ST_IDLE;
            end else begin
              scan_u_q <= scan_u_q + UW'(1);
              state_q  <= ST_RD_UNIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a write to an existing unit leaves idle for the conversion
  `MSS_ASSERT_NXT(a_write_starts, clk_i, rst_ni, (conv_start), (state_q == ST_WRITE), "write did not start conversion")
  // a tick that does not end the count decrements it
  `MSS_ASSERT_NXT(a_tick_counts, clk_i, rst_ni, (in_accept && (in_data_i.cmd == mss_pkg::CMD_TICK) && (refresh_cnt_q != 8'd0)), (refresh_cnt_q == $past(refresh_cnt_q) - 8'd1), "refresh count did not decrement")
  // a blocked result beat keeps the sequencer waiting
  `MSS_ASSERT_NXT(a_out_waits, clk_i, rst_ni, ((state_q == ST_OUT) && out_valid_q && out_stall_i), ((state_q == ST_OUT) && out_valid_q), "scan advanced over a pending beat")
  // the final unit of a scan returns the block to idle
  `MSS_ASSERT_NXT(a_last_idle, clk_i, rst_ni, (out_load && scan_last), (state_q == ST_IDLE), "scan did not end after final unit")
  // digit writes only happen during a write item
  `MSS_ASSERT_IMP(a_dig_we_write, clk_i, rst_ni, (conv_we), (state_q == ST_WRITE), "digit write outside write item")

endmodule
